// File: src/etc2_pkg.sv
// Shared types, tables and bit-field helpers for the ETC2 RGB block decoder.
package etc2_pkg;

  localparam int unsigned BlockWidth = 64;
  localparam int unsigned PixCount   = 16;
  localparam int unsigned IdxWidth   = 4;
  localparam int unsigned ChanWidth  = 8;
  localparam int unsigned OutWidth   = IdxWidth + 3 * ChanWidth;  // 28
  localparam int unsigned OutBytes   = (OutWidth + 7) / 8;
  localparam int unsigned OutTdataW  = OutBytes * 8;              // 32
  localparam int unsigned QueueDepthDef = 2;

  typedef enum logic [2:0] {
    MODE_INDIV,
    MODE_DIFF,
    MODE_T,
    MODE_H,
    MODE_PLANAR
  } mode_t;

  // Classified block handed from the front part to the back part.
  typedef struct packed {
    mode_t      mode;
    logic [7:0] c0r, c0g, c0b;   // base 0 (origin in planar)
    logic [7:0] c1r, c1g, c1b;   // base 1 (horizontal in planar)
    logic [7:0] c2r, c2g, c2b;   // vertical in planar
    logic [6:0] th_dist;         // T/H distance
    logic [2:0] cw0, cw1;        // subblock table codewords
    logic       flip;
    logic [31:0] idx;            // pixel index bits
    logic        h_ge;           // H-mode ordering bit
  } blk_t;

  function automatic logic [7:0] mod_lookup(input logic [2:0] cw, input logic hi);
    logic [7:0] v;
    unique case (cw)
      3'd0: v = hi ? 8'd8   : 8'd2;
      3'd1: v = hi ? 8'd17  : 8'd5;
      3'd2: v = hi ? 8'd29  : 8'd9;
      3'd3: v = hi ? 8'd42  : 8'd13;
      3'd4: v = hi ? 8'd60  : 8'd18;
      3'd5: v = hi ? 8'd80  : 8'd24;
      3'd6: v = hi ? 8'd106 : 8'd33;
      default: v = hi ? 8'd183 : 8'd47;
    endcase
    return v;
  endfunction

  function automatic logic [6:0] dist_lookup(input logic [2:0] s);
    logic [6:0] v;
    unique case (s)
      3'd0: v = 7'd3;
      3'd1: v = 7'd6;
      3'd2: v = 7'd11;
      3'd3: v = 7'd16;
      3'd4: v = 7'd23;
      3'd5: v = 7'd32;
      3'd6: v = 7'd41;
      default: v = 7'd64;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] clamp8(input logic signed [11:0] v);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > 12'sd255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

// File: src/etc2_rgb_block_decoder_top.sv
// Top level of the ETC2 RGB8 block decoder.
//
// The input stream carries one 64-bit compressed block per request on
// in_tdata (first stored byte in bits 63..56). The output stream carries
// sixteen pixel requests per block in row-major order; out_tlast marks the
// sixteenth pixel. out_tdata holds pixel index, red, green, blue.
// The front part classifies a block in the cycle it is accepted and writes
// it into a short queue; the back part reads the queue head and produces
// one registered pixel per cycle while the receiver is ready. The first
// pixel of a block passes from the queue head into the output register.
// The back part has a single pixel path. The queue lets a new block be
// accepted while the previous one is still being emitted.
// Synchronous active-low reset empties the queue and the output register.
// When the receiver holds out_tready low, the output register holds its
// pixel, the back part stops, and once the queue fills in_tready drops.
module etc2_rgb_block_decoder_top
  import etc2_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // block_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // pixel_index[3:0], red, green, blue, zero fill
  output logic        out_tlast   // last
);

  blk_t front_blk, head_blk;
  logic q_full, q_empty, q_pop;
  logic [3:0] pix;
  logic [7:0] r, g, b;

  etc2_front u_front (
    .block_bits(in_tdata),
    .blk       (front_blk)
  );

  etc2_queue #(.Depth(QueueDepth)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_tvalid),
    .push_data(front_blk),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (head_blk),
    .empty    (q_empty)
  );

  etc2_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .blk      (head_blk),
    .blk_valid(!q_empty),
    .blk_pop  (q_pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_pix  (pix),
    .out_r    (r),
    .out_g    (g),
    .out_b    (b),
    .out_last (out_tlast)
  );

  assign in_tready = !q_full;
  assign out_tdata = {4'd0, b, g, r, pix};

  // A popped block must have been present.
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // A stalled pixel keeps its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("output changed under stall");

  // tlast is set exactly on pixel fifteen.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[3:0] == 4'd15)))
    else $error("tlast mismatch");

endmodule

// File: src/etc2_front.sv
// Front part: decodes the block header into mode, base colors and tables.
module etc2_front
  import etc2_pkg::*;
(
  input  logic        [63:0] block_bits,
  output blk_t               blk
);

  logic [7:0] d0, d1, d2, d3, d4, d5, d6, d7;
  logic signed [5:0] sr, sg, sb;
  logic [7:0] hc0r, hc0g, hc0b, hc1r, hc1g, hc1b;
  logic [7:0] tmp;

  assign d0 = block_bits[63:56];
  assign d1 = block_bits[55:48];
  assign d2 = block_bits[47:40];
  assign d3 = block_bits[39:32];
  assign d4 = block_bits[31:24];
  assign d5 = block_bits[23:16];
  assign d6 = block_bits[15:8];
  assign d7 = block_bits[7:0];

  assign sr = $signed({1'b0, d0[7:3]}) + $signed({{3{d0[2]}}, d0[2:0]});
  assign sg = $signed({1'b0, d1[7:3]}) + $signed({{3{d1[2]}}, d1[2:0]});
  assign sb = $signed({1'b0, d2[7:3]}) + $signed({{3{d2[2]}}, d2[2:0]});

  // H-mode base colors are needed for the ordering compare.
  always_comb begin
    hc0r = {d0[6:3], d0[6:3]};
    hc0g = {d0[2:0], d1[4], d0[2:0], d1[4]};
    tmp  = {4'd0, d1[3], d1[1:0], d2[7]};
    hc0b = {tmp[3:0], tmp[3:0]};
    hc1r = {d2[6:3], d2[6:3]};
    hc1g = {d2[2:0], d3[7], d2[2:0], d3[7]};
    hc1b = {d3[6:3], d3[6:3]};
  end

  always_comb begin
    blk      = '0;
    blk.idx  = block_bits[31:0];
    blk.flip = d3[0];
    blk.cw0  = d3[7:5];
    blk.cw1  = d3[4:2];
    blk.h_ge = ({hc0r, hc0g, hc0b} >= {hc1r, hc1g, hc1b});
    if (!d3[1]) begin
      blk.mode = MODE_INDIV;
      blk.c0r = {d0[7:4], d0[7:4]};
      blk.c1r = {d0[3:0], d0[3:0]};
      blk.c0g = {d1[7:4], d1[7:4]};
      blk.c1g = {d1[3:0], d1[3:0]};
      blk.c0b = {d2[7:4], d2[7:4]};
      blk.c1b = {d2[3:0], d2[3:0]};
    end else if (sr[5]) begin
      // T mode: red leaves 0..31 (bit 5 covers both signs for this range).
      blk.mode = MODE_T;
      blk.c0r = {d0[4:3], d0[1:0], d0[4:3], d0[1:0]};
      blk.c0g = {d1[7:4], d1[7:4]};
      blk.c0b = {d1[3:0], d1[3:0]};
      blk.c1r = {d2[7:4], d2[7:4]};
      blk.c1g = {d2[3:0], d2[3:0]};
      blk.c1b = {d3[7:4], d3[7:4]};
      blk.th_dist = dist_lookup({d3[3:2], d3[0]});
    end else if (sg[5]) begin
      blk.mode = MODE_H;
      blk.c0r = hc0r; blk.c0g = hc0g; blk.c0b = hc0b;
      blk.c1r = hc1r; blk.c1g = hc1g; blk.c1b = hc1b;
      blk.th_dist = dist_lookup({d3[2], d3[0], blk.h_ge});
    end else if (sb[5]) begin
      blk.mode = MODE_PLANAR;
      blk.c0r = {d0[6:1], d0[6:5]};
      blk.c0g = {d0[0], d1[6:1], d0[0]};
      blk.c0b = {d1[0], d2[4:3], d2[1:0], d3[7], d1[0], d2[4]};
      blk.c1r = {d3[6:2], d3[0], d3[6:5]};
      blk.c1g = {d4[7:1], d4[7]};
      blk.c1b = {d4[0], d5[7:3], d4[0], d5[7]};
      blk.c2r = {d5[2:0], d6[7:5], d5[2:1]};
      blk.c2g = {d6[4:0], d7[7:6], d6[4]};
      blk.c2b = {d7[5:0], d7[5:4]};
    end else begin
      blk.mode = MODE_DIFF;
      blk.c0r = {d0[7:3], d0[7:5]};
      blk.c0g = {d1[7:3], d1[7:5]};
      blk.c0b = {d2[7:3], d2[7:5]};
      blk.c1r = {sr[4:0], sr[4:2]};
      blk.c1g = {sg[4:0], sg[4:2]};
      blk.c1b = {sb[4:0], sb[4:2]};
    end
  end

endmodule

// File: src/etc2_queue.sv
// Small FIFO of classified blocks between the front and back parts.
module etc2_queue
  import etc2_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  blk_t push_data,
  output logic full,
  input  logic pop,
  output blk_t pop_data,
  output logic empty
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  blk_t mem_r [Depth];
  logic [PtrW-1:0] wr_r, rd_r;
  logic [PtrW:0]   cnt_r;

  assign full     = (cnt_r == (PtrW+1)'(Depth));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) begin
        wr_r <= (wr_r == PtrW'(Depth - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_r <= (rd_r == PtrW'(Depth - 1)) ? '0 : rd_r + 1'b1;
      end
      cnt_r <= cnt_r + (PtrW+1)'(push && !full) - (PtrW+1)'(pop && !empty);
    end
  end

endmodule

// File: src/etc2_back.sv
// Back part: walks the sixteen pixels of a block and registers each result.
module etc2_back
  import etc2_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  blk_t        blk,
  input  logic        blk_valid,
  output logic        blk_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_pix,
  output logic [7:0]  out_r,
  output logic [7:0]  out_g,
  output logic [7:0]  out_b,
  output logic        out_last
);

  logic [3:0] pix_r;
  logic       valid_r;
  logic [3:0] opix_r;
  logic [7:0] or_r, og_r, ob_r;
  logic       advance;
  logic [1:0] x, y;
  logic [3:0] bi;
  logic [1:0] q;
  logic       s;
  logic signed [8:0] delta;
  logic [7:0] br, bg, bb;
  logic [7:0] pr, pg, pb;

  assign x  = pix_r[1:0];
  assign y  = pix_r[3:2];
  assign bi = {x, y};
  assign q  = {blk.idx[16 + bi], blk.idx[bi]};

  assign advance = blk_valid && (!valid_r || out_ready);
  assign blk_pop = advance && (pix_r == 4'd15);

  function automatic logic [7:0] planar(input logic [7:0] o, input logic [7:0] h,
                                        input logic [7:0] v, input logic [1:0] px,
                                        input logic [1:0] py);
    logic signed [12:0] t;
    t = $signed({3'd0, px}) * ($signed({1'b0, h}) - $signed({1'b0, o}))
      + $signed({3'd0, py}) * ($signed({1'b0, v}) - $signed({1'b0, o}))
      + $signed({3'b0, o, 2'b10});
    return clamp8(12'(t >>> 2));
  endfunction

  always_comb begin
    s     = blk.flip ? y[1] : x[1];
    delta = '0;
    br = blk.c0r; bg = blk.c0g; bb = blk.c0b;
    pr = '0; pg = '0; pb = '0;
    unique case (blk.mode)
      MODE_INDIV, MODE_DIFF: begin
        delta = $signed({1'b0, mod_lookup(s ? blk.cw1 : blk.cw0, q[0])});
        if (q[1]) delta = -delta;
        if (s) begin
          br = blk.c1r; bg = blk.c1g; bb = blk.c1b;
        end
      end
      MODE_T: begin
        if (q != 2'd0) begin
          br = blk.c1r; bg = blk.c1g; bb = blk.c1b;
        end
        if (q == 2'd1) delta = $signed({2'b0, blk.th_dist});
        if (q == 2'd3) delta = -$signed({2'b0, blk.th_dist});
      end
      MODE_H: begin
        if (q[1]) begin
          br = blk.c1r; bg = blk.c1g; bb = blk.c1b;
        end
        delta = q[0] ? -$signed({2'b0, blk.th_dist}) : $signed({2'b0, blk.th_dist});
      end
      default: begin
        pr = planar(blk.c0r, blk.c1r, blk.c2r, x, y);
        pg = planar(blk.c0g, blk.c1g, blk.c2g, x, y);
        pb = planar(blk.c0b, blk.c1b, blk.c2b, x, y);
      end
    endcase
    if (blk.mode != MODE_PLANAR) begin
      pr = clamp8($signed({4'b0, br}) + 12'(delta));
      pg = clamp8($signed({4'b0, bg}) + 12'(delta));
      pb = clamp8($signed({4'b0, bb}) + 12'(delta));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (advance) begin
        pix_r   <= pix_r + 1'b1;
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      opix_r <= pix_r;
      or_r   <= pr;
      og_r   <= pg;
      ob_r   <= pb;
    end
  end

  assign out_valid = valid_r;
  assign out_pix   = opix_r;
  assign out_r     = or_r;
  assign out_g     = og_r;
  assign out_b     = ob_r;
  assign out_last  = (opix_r == 4'd15);

endmodule

// File: sim/tb_etc2_rgb_block_decoder_top.sv
// Self-checking testbench for the ETC2 RGB8 block decoder top level.
module tb_etc2_rgb_block_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;
  import etc2_pkg::*;

  // One decoded pixel as it is expected on the output stream.
  typedef struct {
    logic [3:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;    // block_bits
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;   // pixel_index[3:0], red, green, blue, zero fill
  logic        out_tlast;   // last

  logic [63:0] block_queue[$];   // blocks waiting to be offered
  pixel_t      pixel_queue[$];   // decoded pixels still to arrive
  int          error_count = 0;
  int          sender_gap = 0;
  int          receiver_gap = 0;
  int          hold_off_cycles = 0;  // long receiver stall requested by the stimulus
  bit          stim_done = 0;
  bit          in_fire = 0;          // input request taken at the last rising edge

  etc2_rgb_block_decoder_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] clip_channel(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic int codeword_offset(logic [2:0] cw, logic hi);
    int lo_tab[8] = '{2, 5, 9, 13, 18, 24, 33, 47};
    int hi_tab[8] = '{8, 17, 29, 42, 60, 80, 106, 183};
    return hi ? hi_tab[cw] : lo_tab[cw];
  endfunction

  function automatic int th_distance(logic [2:0] s);
    int tab[8] = '{3, 6, 11, 16, 23, 32, 41, 64};
    return tab[s];
  endfunction

  function automatic int signed_3bit(logic [2:0] v);
    return v[2] ? int'(v) - 8 : int'(v);
  endfunction

  function automatic logic [7:0] widen5(logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  // The two index bits of pixel p: column-major bit positions in the block.
  function automatic logic [1:0] pixel_code(logic [63:0] blk, int p);
    int i;
    i = (p % 4) * 4 + p / 4;
    return {blk[16 + i], blk[i]};
  endfunction

  // Decodes one block into its sixteen expected pixels.
  task automatic decode_block(input logic [63:0] blk);
    logic [7:0] b[8];
    logic [7:0] base[3][3];
    logic [7:0] pal[4][3];
    logic [2:0] cw[2];
    logic [1:0] q;
    logic [23:0] v1;
    logic [23:0] v2;
    logic [2:0] sel;
    int sr, sg, sb, th_step, m, s, t, o, x, y, p, ch;
    bit paletted;
    bit planar;
    pixel_t px;
    for (int n = 0; n < 8; n++) b[n] = blk[63 - 8 * n -: 8];
    paletted = 0;
    planar = 0;
    sr = int'(b[0][7:3]) + signed_3bit(b[0][2:0]);
    sg = int'(b[1][7:3]) + signed_3bit(b[1][2:0]);
    sb = int'(b[2][7:3]) + signed_3bit(b[2][2:0]);
    if (!b[3][1]) begin
      // Individual mode: two 4-bit base colors per channel.
      base[0][0] = {b[0][7:4], b[0][7:4]};
      base[1][0] = {b[0][3:0], b[0][3:0]};
      base[0][1] = {b[1][7:4], b[1][7:4]};
      base[1][1] = {b[1][3:0], b[1][3:0]};
      base[0][2] = {b[2][7:4], b[2][7:4]};
      base[1][2] = {b[2][3:0], b[2][3:0]};
    end else if (sr < 0 || sr > 31) begin
      // T mode.
      paletted = 1;
      base[0][0] = {b[0][4:3], b[0][1:0], b[0][4:3], b[0][1:0]};
      base[0][1] = {b[1][7:4], b[1][7:4]};
      base[0][2] = {b[1][3:0], b[1][3:0]};
      base[1][0] = {b[2][7:4], b[2][7:4]};
      base[1][1] = {b[2][3:0], b[2][3:0]};
      base[1][2] = {b[3][7:4], b[3][7:4]};
      th_step = th_distance({b[3][3:2], b[3][0]});
      for (ch = 0; ch < 3; ch++) begin
        pal[0][ch] = base[0][ch];
        pal[1][ch] = clip_channel(int'(base[1][ch]) + th_step);
        pal[2][ch] = base[1][ch];
        pal[3][ch] = clip_channel(int'(base[1][ch]) - th_step);
      end
    end else if (sg < 0 || sg > 31) begin
      // H mode, with the ordering bit from comparing the two bases.
      paletted = 1;
      base[0][0] = {b[0][6:3], b[0][6:3]};
      base[0][1] = {b[0][2:0], b[1][4], b[0][2:0], b[1][4]};
      base[0][2] = {b[1][3], b[1][1:0], b[2][7], b[1][3], b[1][1:0], b[2][7]};
      base[1][0] = {b[2][6:3], b[2][6:3]};
      base[1][1] = {b[2][2:0], b[3][7], b[2][2:0], b[3][7]};
      base[1][2] = {b[3][6:3], b[3][6:3]};
      v1 = {base[0][0], base[0][1], base[0][2]};
      v2 = {base[1][0], base[1][1], base[1][2]};
      sel = {b[3][2], b[3][0], (v1 >= v2)};
      th_step = th_distance(sel);
      for (ch = 0; ch < 3; ch++) begin
        pal[0][ch] = clip_channel(int'(base[0][ch]) + th_step);
        pal[1][ch] = clip_channel(int'(base[0][ch]) - th_step);
        pal[2][ch] = clip_channel(int'(base[1][ch]) + th_step);
        pal[3][ch] = clip_channel(int'(base[1][ch]) - th_step);
      end
    end else if (sb < 0 || sb > 31) begin
      // Planar mode: origin, horizontal and vertical colors.
      planar = 1;
      base[0][0] = {b[0][6:1], b[0][6:5]};
      base[0][1] = {b[0][0], b[1][6:1], b[0][0]};
      base[0][2] = {b[1][0], b[2][4:3], b[2][1:0], b[3][7], b[1][0], b[2][4]};
      base[1][0] = {b[3][6:2], b[3][0], b[3][6:5]};
      base[1][1] = {b[4][7:1], b[4][7]};
      base[1][2] = {b[4][0], b[5][7:3], b[4][0], b[5][7]};
      base[2][0] = {b[5][2:0], b[6][7:5], b[5][2:1]};
      base[2][1] = {b[6][4:0], b[7][7:6], b[6][4]};
      base[2][2] = {b[7][5:0], b[7][5:4]};
    end else begin
      // Differential mode: second base is the first plus a signed delta.
      base[0][0] = widen5(b[0][7:3]);
      base[0][1] = widen5(b[1][7:3]);
      base[0][2] = widen5(b[2][7:3]);
      base[1][0] = widen5(sr[4:0]);
      base[1][1] = widen5(sg[4:0]);
      base[1][2] = widen5(sb[4:0]);
    end
    cw[0] = b[3][7:5];
    cw[1] = b[3][4:2];
    for (p = 0; p < 16; p++) begin
      x = p % 4;
      y = p / 4;
      q = pixel_code(blk, p);
      px.pixel_index = p[3:0];
      px.last = (p == 15);
      if (planar) begin
        for (ch = 0; ch < 3; ch++) begin
          o = int'(base[0][ch]);
          t = x * (int'(base[1][ch]) - o) + y * (int'(base[2][ch]) - o) + 4 * o + 2;
          pal[0][ch] = (t < 0) ? 8'd0 : clip_channel(t / 4);
        end
        q = 2'd0;
      end else if (!paletted) begin
        s = b[3][0] ? (y >= 2) : (x >= 2);
        m = codeword_offset(cw[s], q[0]);
        if (q[1]) m = -m;
        for (ch = 0; ch < 3; ch++) pal[0][ch] = clip_channel(int'(base[s][ch]) + m);
        q = 2'd0;
      end
      px.red = pal[q][0];
      px.green = pal[q][1];
      px.blue = pal[q][2];
      pixel_queue.push_back(px);
    end
  endtask

  // Random block steered toward one mode; random payload everywhere else.
  function automatic logic [63:0] random_block(int mode);
    logic [63:0] blk;
    logic [4:0] base;
    logic [2:0] delta;
    int sum;
    blk = {$urandom, $urandom};
    if (mode == 0) begin
      blk[33] = 1'b0;
      return blk;
    end
    blk[33] = 1'b1;
    // Redraw each channel's base/delta pair until it lands where the mode needs it.
    for (int ch = 0; ch < 3; ch++) begin
      bit want_over;
      want_over = (mode == 2 && ch == 0) || (mode == 3 && ch == 1) || (mode == 4 && ch == 2);
      if ((mode == 3 && ch == 0) || (mode == 4 && ch < 2) || mode == 1 || want_over) begin
        do begin
          base = 5'($urandom);
          delta = 3'($urandom);
          sum = int'(base) + (delta[2] ? int'(delta) - 8 : int'(delta));
        end while (((sum < 0) || (sum > 31)) != want_over);
        blk[63 - 8 * ch -: 8] = {base, delta};
      end
    end
    return blk;
  endfunction

  // Records whether the input request was taken at this rising edge.
  always @(posedge clk) begin
    in_fire <= rst_n && in_tvalid && in_tready;
  end

  // Driver: offers queued blocks with random gaps; changes at the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_fire) begin
      // Request still pending; hold it.
    end else if (sender_gap > 0) begin
      in_tvalid <= 1'b0;
      sender_gap <= sender_gap - 1;
    end else if (block_queue.size() > 0) begin
      in_tvalid <= 1'b1;
      in_tdata <= block_queue.pop_front();
      sender_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Receiver ready: random stalls, plus a long hold-off when requested.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      out_tready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else if (receiver_gap > 0) begin
      out_tready <= 1'b0;
      receiver_gap <= receiver_gap - 1;
    end else begin
      out_tready <= 1'b1;
      if (out_tvalid) receiver_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
    end
  end

  // Accepted input blocks are decoded into expectations right at the edge.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) decode_block(in_tdata);
  end

  // Monitor: each accepted pixel is compared with the oldest expectation.
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pixel_queue.size() == 0) begin
        $error("unexpected pixel request: tdata=%h", out_tdata);
        error_count++;
      end else begin
        want = pixel_queue.pop_front();
        if (out_tdata[3:0] !== want.pixel_index) begin
          $error("pixel_index: expected %0d, got %0d", want.pixel_index, out_tdata[3:0]);
          error_count++;
        end
        if (out_tdata[11:4] !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, out_tdata[11:4]);
          error_count++;
        end
        if (out_tdata[19:12] !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, out_tdata[19:12]);
          error_count++;
        end
        if (out_tdata[27:20] !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, out_tdata[27:20]);
          error_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_tlast);
          error_count++;
        end
      end
    end
  end

  // Stimulus: a directed part covering every mode and its corner cases,
  // a pause until all pixels are back, a long receiver stall, then random blocks.
  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Field extremes: all zeros, all ones, alternating patterns.
    block_queue.push_back(64'h0);
    block_queue.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    block_queue.push_back(64'hAAAA_AAAA_AAAA_AAAA);
    block_queue.push_back(64'h5555_5555_5555_5555);
    // Individual mode with saturating codewords, both flip settings.
    block_queue.push_back(64'hF00F_F0FC_FFFF_0000);
    block_queue.push_back(64'h0FF0_0FFD_0000_FFFF);
    // Differential with the largest positive and negative deltas.
    block_queue.push_back(64'h0B0B_0BE2_1234_5678);
    block_queue.push_back(64'hFCFC_FC1F_8765_4321);
    // T mode: red base plus delta underflows and overflows.
    block_queue.push_back(64'h04FF_00FF_FFFF_0000);
    block_queue.push_back(64'hFB00_FF0E_0F0F_F0F0);
    // H mode: ordering bit taken both ways (bases equal and base 1 larger).
    block_queue.push_back(64'h0004_0002_0000_FFFF);
    block_queue.push_back(64'h0004_FF7F_3C3C_C3C3);
    // Planar with the origin at zero; the next two blocks decode as differential.
    block_queue.push_back(64'h0000_0402_0000_0000);
    block_queue.push_back(64'h7E7F_FC7F_FFFF_FFFF);
    block_queue.push_back(64'h7E7F_FC02_0000_0000);
    for (int i = 0; i < 6; i++) block_queue.push_back(random_block(i % 5));

    // Sender pause: wait until every directed pixel has come back.
    wait (block_queue.size() == 0 && !in_tvalid);
    wait (pixel_queue.size() == 0);

    // Long receiver hold-off while the sender keeps offering blocks,
    // so the internal queue fills and input ready drops.
    @(negedge clk);
    hold_off_cycles = 120;
    for (int i = 0; i < 8; i++) block_queue.push_back(random_block(i % 5));

    // Random part, well-formed per mode with a share of raw noise.
    for (int i = 0; i < 250; i++) begin
      if ($urandom_range(0, 5) == 0) block_queue.push_back({$urandom, $urandom});
      else block_queue.push_back(random_block($urandom_range(0, 4)));
    end

    wait (block_queue.size() == 0 && !in_tvalid);
    wait (pixel_queue.size() == 0);
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run of ~300 blocks.
  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
